// ===== design/mclk_pkg.sv =====
package mclk_pkg;

  localparam int MAX_ROUNDS   = 64;
  localparam int LEN_W        = 7;
  localparam int KS_W         = 64;
  localparam int STATE_W      = 64;
  localparam int LEN_A        = 19;
  localparam int LEN_B        = 22;
  localparam int LEN_C        = 23;
  localparam int RND_PER_STG  = 8;
  localparam int NUM_STAGES   = (MAX_ROUNDS + RND_PER_STG - 1) / RND_PER_STG;
  localparam int RND_W        = $clog2(RND_PER_STG);
  localparam int STG_W        = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;
  localparam int ADDR_W       = 3;
  localparam int DATA_W       = 32;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(MAX_ROUNDS);
  localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MAX_ROUNDS);

  localparam logic REG_IDX_LENGTH = 1'b0;

  typedef struct packed {
    logic [LEN_C-1:0] c;
    logic [LEN_B-1:0] b;
    logic [LEN_A-1:0] a;
  } gen_state_t;

  typedef struct packed {
    gen_state_t       st;
    logic [KS_W-1:0]  acc;
    logic [LEN_W-1:0] len;
  } stage_data_t;

  function automatic logic ks_bit(input gen_state_t s);
    ks_bit = s.a[LEN_A-1] ^ s.b[LEN_B-1] ^ s.c[LEN_C-1];
  endfunction

  function automatic gen_state_t gen_step(input gen_state_t s);
    logic maj;
    gen_state_t n;
    maj = (s.a[8] & s.b[10]) | (s.b[10] & s.c[10]) | (s.c[10] & s.a[8]);
    n = s;
    if (s.a[8] == maj) begin
      n.a = {s.a[LEN_A-2:0], s.a[18] ^ s.a[17] ^ s.a[16] ^ s.a[13]};
    end
    if (s.b[10] == maj) begin
      n.b = {s.b[LEN_B-2:0], s.b[21] ^ s.b[20]};
    end
    if (s.c[10] == maj) begin
      n.c = {s.c[LEN_C-2:0], s.c[22] ^ s.c[21] ^ s.c[20] ^ s.c[7]};
    end
    gen_step = n;
  endfunction

endpackage

// ===== design/majority_clocked_lfsr_keystream_top.sv =====
// Majority-clocked LFSR keystream generator (A5/1-style), pipelined.
// Input channel: in_valid/in_ready with in_initial_state, the packed
// generator state (A in bits 0-18, B in bits 19-40, C in bits 41-63).
// Output channel: out_valid/out_ready with out_keystream, one result per
// input transaction, in order. The first keystream bit is the highest
// used bit; bits above the configured length are zero.
// Config: APB register 0 (byte address 0) is keystream_length, 7 bits,
// reset 64; values above 64 are saturated to 64, 0 gives a zero result.
// Write it only while the pipeline is empty.
// Pipeline: eight register stages of eight generator clocks each. Throughput:
// one transaction per cycle while out_ready is high.
// Reset empties the pipeline and sets the length to 64.
// When out_ready is low the stages fill up; in_ready drops only once
// every stage holds a transaction, and nothing is dropped or repeated.
module majority_clocked_lfsr_keystream_top import mclk_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [STATE_W-1:0] in_initial_state,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [KS_W-1:0]    out_keystream,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  logic [LEN_W-1:0] len_eff;
  logic             vld [NUM_STAGES+1];
  logic             rdy [NUM_STAGES+1];
  stage_data_t      dat [NUM_STAGES+1];

  mclk_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .len_eff (len_eff)
  );

  assign vld[0]        = in_valid;
  assign in_ready      = rdy[0];
  assign dat[0].st     = gen_state_t'(in_initial_state);
  assign dat[0].acc    = '0;
  assign dat[0].len    = len_eff;

  for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
    mclk_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .stage_idx (STG_W'(s)),
      .up_valid  (vld[s]),
      .up_ready  (rdy[s]),
      .up_data   (dat[s]),
      .dn_valid  (vld[s+1]),
      .dn_ready  (rdy[s+1]),
      .dn_data   (dat[s+1])
    );
  end

  assign out_valid          = vld[NUM_STAGES];
  assign rdy[NUM_STAGES]    = out_ready;
  assign out_keystream      = dat[NUM_STAGES].acc;

  a_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && dat[NUM_STAGES].len < LEN_MAX |->
      (out_keystream >> dat[NUM_STAGES].len) == '0)
    else $error("keystream bits set above configured length");

  a_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && dat[NUM_STAGES].len == '0 |-> out_keystream == '0)
    else $error("nonzero keystream for zero length");

  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> !out_ready && out_valid && vld[1])
    else $error("input stalled while pipeline has room");

endmodule

// ===== design/mclk_cfg.sv =====
module mclk_cfg import mclk_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output logic [LEN_W-1:0]  len_eff
);

  logic [LEN_W-1:0] len_r;
  logic [LEN_W-1:0] len_nxt;
  logic             wr_len;

  assign pready = 1'b1;
  assign wr_len = psel && penable && pwrite && (paddr[ADDR_W-1] == REG_IDX_LENGTH);

  always_comb begin
    len_nxt = len_r;
    if (wr_len) begin
      len_nxt = pwdata[LEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= LEN_RESET;
    end else begin
      len_r <= len_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[ADDR_W-1] == REG_IDX_LENGTH) begin
      prdata = DATA_W'(len_r);
    end
  end

  assign len_eff = (len_r > LEN_MAX) ? LEN_MAX : len_r;

  a_len_write: assert property (@(posedge clk) disable iff (!rst_n)
    wr_len |=> len_r == $past(pwdata[LEN_W-1:0]))
    else $error("length register write lost");

  a_len_sat: assert property (@(posedge clk) disable iff (!rst_n)
    len_eff <= LEN_MAX && (len_r > LEN_MAX || len_eff == len_r))
    else $error("effective length out of range");

  a_len_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !wr_len |=> $stable(len_r))
    else $error("length register changed without write");

endmodule

// ===== design/mclk_stage.sv =====
module mclk_stage import mclk_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [STG_W-1:0] stage_idx,
  input  logic             up_valid,
  output logic             up_ready,
  input  stage_data_t      up_data,
  output logic             dn_valid,
  input  logic             dn_ready,
  output stage_data_t      dn_data
);

  logic        valid_r;
  logic        valid_nxt;
  stage_data_t data_r;
  stage_data_t data_nxt;

  always_comb begin
    gen_state_t       st;
    logic [KS_W-1:0]  acc;
    logic [LEN_W-1:0] rnd;
    st  = up_data.st;
    acc = up_data.acc;
    for (int j = 0; j < RND_PER_STG; j++) begin
      rnd = LEN_W'({stage_idx, RND_W'(j)});
      if (rnd < up_data.len) begin
        acc = {acc[KS_W-2:0], ks_bit(st)};
        st  = gen_step(st);
      end
    end
    data_nxt.st  = st;
    data_nxt.acc = acc;
    data_nxt.len = up_data.len;
  end

  assign up_ready  = !valid_r || dn_ready;
  assign valid_nxt = up_ready ? up_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule
